// File: hw/rtl/packed_bcd_multibyte_add_saturating_assert.svh
// assertion macros for the packed bcd adder
`ifndef PACKED_BCD_MULTIBYTE_ADD_SATURATING_ASSERT_SVH
`define PACKED_BCD_MULTIBYTE_ADD_SATURATING_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define PBCD_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("pbcd check failed");

// condition in this cycle implies consequence in the next cycle
`define PBCD_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("pbcd check failed");

`endif

// File: hw/rtl/pbcd_pkg.sv
// shared constants and types for the packed bcd adder
package pbcd_pkg;

  localparam int MAX_BYTES = 8;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 3;

  localparam logic [CNT_W-1:0] BYTE_COUNT_RESET = 4'd3;
  localparam logic [7:0]       FILL_BYTE        = 8'h99;
  localparam logic [7:0]       ADJ_HIGH         = 8'h60;
  localparam logic [7:0]       ADJ_LOW          = 8'h06;
  localparam logic [3:0]       DIGIT_MAX        = 4'd9;

  typedef enum logic [0:0] {
    S_IDLE,
    S_FILL
  } pbcd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take_pair;
    logic take_fill;
  } pbcd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic final_pair;
    logic final_carry;
    logic fill_done;
  } pbcd_stat_t;

endpackage

// File: hw/rtl/pbcd_ctrl.sv
// controller: handshakes, output valid and saturation fill sequencing
module pbcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pbcd_pkg::pbcd_stat_t stat,
  output pbcd_pkg::pbcd_cmd_t  cmd
);
  import pbcd_pkg::*;

  pbcd_state_t state, state_next;
  logic        out_valid_next;
  logic        slot_free;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state, commands and handshake
  always_comb begin
    slot_free     = !out_valid || !out_stall;
    in_stall      = !((state == S_IDLE) && slot_free);
    cmd.take_pair = in_valid && !in_stall;
    cmd.take_fill = (state == S_FILL) && slot_free;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take_pair && stat.final_pair && stat.final_carry) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (cmd.take_fill && stat.fill_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.take_pair || cmd.take_fill) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: hw/rtl/pbcd_dp.sv
// datapath: decimal add and adjust, position tracking, result register
module pbcd_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pbcd_pkg::CNT_W-1:0]  cfg_data,
  input  logic [7:0]                  left_byte,
  input  logic [7:0]                  right_byte,
  input  pbcd_pkg::pbcd_cmd_t         cmd,
  output pbcd_pkg::pbcd_stat_t        stat,
  output logic [7:0]                  sum_byte,
  output logic [pbcd_pkg::IDX_W-1:0]  byte_index,
  output logic                        saturated,
  output logic                        last
);
  import pbcd_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic             decimal_carry;
  logic [IDX_W-1:0] position;
  logic [IDX_W-1:0] fill_index;

  logic [CNT_W-1:0] active_len;
  logic [8:0]       wide;
  logic [4:0]       low_sum;
  logic             carry;
  logic [7:0]       corr;
  logic [7:0]       adj_sum;
  logic [CNT_W-1:0] pos_plus;

  // length clamp and decimal adjust
  always_comb begin
    if (byte_count == '0) begin
      active_len = CNT_W'(1);
    end else if (byte_count > CNT_W'(MAX_BYTES)) begin
      active_len = CNT_W'(MAX_BYTES);
    end else begin
      active_len = byte_count;
    end
    wide    = {1'b0, left_byte} + {1'b0, right_byte} + {8'd0, decimal_carry};
    low_sum = {1'b0, left_byte[3:0]} + {1'b0, right_byte[3:0]} + {4'd0, decimal_carry};
    carry   = wide[8] || (wide[7:0] > FILL_BYTE);
    corr    = 8'd0;
    if (carry) begin
      corr = corr | ADJ_HIGH;
    end
    if (low_sum[4] || (wide[3:0] > DIGIT_MAX)) begin
      corr = corr | ADJ_LOW;
    end
    adj_sum          = wide[7:0] + corr;
    pos_plus         = {1'b0, position} + CNT_W'(1);
    stat.final_pair  = pos_plus >= active_len;
    stat.final_carry = carry;
    stat.fill_done   = (fill_index == '0);
  end

  // configuration and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= BYTE_COUNT_RESET;
      decimal_carry <= 1'b0;
      position      <= '0;
    end else begin
      if (cfg_we) begin
        byte_count <= cfg_data;
      end
      if (cmd.take_pair) begin
        if (stat.final_pair) begin
          decimal_carry <= 1'b0;
          position      <= '0;
        end else begin
          decimal_carry <= carry;
          position      <= pos_plus[IDX_W-1:0];
        end
      end
    end
  end

  // fill counter and result register
  always_ff @(posedge clk) begin
    if (cmd.take_pair) begin
      sum_byte   <= adj_sum;
      byte_index <= position;
      saturated  <= 1'b0;
      last       <= stat.final_pair && !carry;
      fill_index <= IDX_W'(active_len - CNT_W'(1));
    end else if (cmd.take_fill) begin
      sum_byte   <= FILL_BYTE;
      byte_index <= fill_index;
      saturated  <= 1'b1;
      last       <= (fill_index == '0);
      fill_index <= fill_index - IDX_W'(1);
    end
  end

endmodule

// File: hw/rtl/packed_bcd_multibyte_add_saturating.sv
// top level: packed bcd multibyte adder with saturation fill
// a byte pair's sum byte is registered and valid in the cycle after its transfer
// throughput: one pair per cycle while the result register drains each cycle
// a final pair with carry out is followed by one fill byte per byte of the clamped length
// (0x99 each) during which no pair is taken; the result register sets the pace
// reset (rst, synchronous): byte_count to 3, carry and position to zero, no result
module packed_bcd_multibyte_add_saturating (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pbcd_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  left_byte,
  input  logic [7:0]                  right_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  sum_byte,
  output logic [pbcd_pkg::IDX_W-1:0]  byte_index,
  output logic                        saturated,
  output logic                        last
);
  import pbcd_pkg::*;

  pbcd_cmd_t  cmd;
  pbcd_stat_t stat;

  // sequencing and handshakes
  pbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and result register
  pbcd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .left_byte  (left_byte),
    .right_byte (right_byte),
    .cmd        (cmd),
    .stat       (stat),
    .sum_byte   (sum_byte),
    .byte_index (byte_index),
    .saturated  (saturated),
    .last       (last)
  );

`include "packed_bcd_multibyte_add_saturating_assert.svh"

  // no pair is taken while the fill runs
  `PBCD_ASSERT_SAME(a_fill_blocks_input, cmd.take_fill, in_stall && !cmd.take_pair)
  // the last fill byte is the least significant one
  `PBCD_ASSERT_SAME(a_fill_ends_at_zero, out_valid && saturated && last, byte_index == '0)
  // fill bytes follow each other without a gap
  `PBCD_ASSERT_NEXT(a_fill_no_gap, out_valid && !out_stall && saturated && !last,
                    out_valid && saturated)

endmodule
